FILE: hw/rtl/rsma_pkg.sv
// Shared types for the running-sum moving average unit.
// No dependencies; imported by the engine, the input queue, the top level and the testbench.
package rsma_pkg;

    // Width of the window length register as seen on the configuration port.
    localparam int CFG_BITS = 7;
    // Window length after reset, before any clamping to the window maximum.
    localparam int RESET_LENGTH = 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_PREP,
        ST_DIVIDE,
        ST_DONE
    } engine_state_t;

    typedef struct packed {
        logic                wr_en;
        logic [CFG_BITS-1:0] wr_data;
    } cfg_write_t;

    typedef struct packed {
        logic idle;
        logic pop;
        logic load;
    } engine_status_t;

endpackage

FILE: hw/rtl/rsma_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module rsma_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                                     aclk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/rsma_front.sv
// Input side of the moving average unit: takes sample beats and holds them
// in a two-entry queue for the engine. Uses rsma_pkg for the engine status.
module rsma_front #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,   // sample
    input  rsma_pkg::engine_status_t              eng_status,
    output logic                                  q_valid,
    output logic signed [SAMPLE_BITS-1:0]         q_sample
);
    import rsma_pkg::*;

    logic signed [SAMPLE_BITS-1:0] entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;

    assign s_axis_tready = (count_reg != 2'd2);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign q_valid       = (count_reg != 2'd0);
    assign q_sample      = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = eng_status.pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !eng_status.pop) begin
            count_next = count_reg + 2'd1;
        end else if (!push && eng_status.pop) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= s_axis_tdata[SAMPLE_BITS-1:0];
        end
    end

endmodule

FILE: hw/rtl/rsma_engine.sv
// Back end of the moving average unit: ring update, running sum, serial
// divider and output register. Uses rsma_pkg and one rsma_ram for the ring.
module rsma_engine #(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  rsma_pkg::cfg_write_t                  cfg,
    input  logic                                  q_valid,
    input  logic signed [SAMPLE_BITS-1:0]         q_sample,
    output rsma_pkg::engine_status_t              eng_status,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] m_axis_tdata,   // average
    output logic                                  m_axis_tuser    // window_full
);
    import rsma_pkg::*;

    localparam int PTR_W   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int LEN_W   = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W   = SAMPLE_BITS + $clog2(WINDOW_MAX);
    localparam int CNT_W   = $clog2(SUM_W + 1);
    localparam int CMP_W   = (CFG_BITS > LEN_W) ? CFG_BITS : LEN_W;
    localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int INIT_LEN = (RESET_LENGTH > WINDOW_MAX) ? WINDOW_MAX : RESET_LENGTH;

    engine_state_t state_reg, state_next;

    logic [LEN_W-1:0]              len_reg, len_next;
    logic [LEN_W-1:0]              fill_reg, fill_next;
    logic [PTR_W-1:0]              wp_reg, wp_next;
    logic signed [SUM_W-1:0]       sum_reg, sum_next;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic [SUM_W-1:0]              quot_reg, quot_next;
    logic [LEN_W-1:0]              rem_reg, rem_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic                          neg_reg;
    logic                          full_flag_reg;
    logic                          out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] avg_reg;
    logic                          out_full_reg;

    logic                          ram_rd_en, ram_wr_en;
    logic signed [SAMPLE_BITS-1:0] ram_rd_data;
    logic                          pop, load, slot_free;
    logic                          window_was_full;
    logic [CMP_W-1:0]              cfg_len;
    logic [LEN_W-1:0]              wp_inc;
    logic [LEN_W:0]                rem_shift, rem_diff;
    logic [SUM_W-1:0]              quot_signed;

    rsma_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (wp_reg),
        .wr_data (sample_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (wp_reg),
        .rd_data (ram_rd_data)
    );

    assign slot_free = !out_valid_reg || m_axis_tready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (q_valid) state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_PREP;
            ST_PREP:   state_next = ST_DIVIDE;
            ST_DIVIDE: if (cnt_reg == CNT_W'(1)) state_next = ST_DONE;
            ST_DONE:   if (slot_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        pop       = 1'b0;
        ram_rd_en = 1'b0;
        ram_wr_en = 1'b0;
        load      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                pop       = q_valid;
                ram_rd_en = q_valid;
            end
            ST_UPDATE: ram_wr_en = 1'b1;
            ST_DONE:   load = slot_free;
            default: ;
        endcase
    end

    assign eng_status.idle = (state_reg == ST_IDLE);
    assign eng_status.pop  = pop;
    assign eng_status.load = load;

    // Datapath next values.
    always_comb begin
        cfg_len = CMP_W'(cfg.wr_data);
        if (cfg_len == '0) begin
            cfg_len = CMP_W'(1);
        end else if (cfg_len > CMP_W'(WINDOW_MAX)) begin
            cfg_len = CMP_W'(WINDOW_MAX);
        end

        window_was_full = (fill_reg >= len_reg);
        wp_inc          = LEN_W'(wp_reg) + LEN_W'(1);
        rem_shift       = {rem_reg, quot_reg[SUM_W-1]};
        rem_diff        = rem_shift - {1'b0, fill_reg};
        quot_signed     = neg_reg ? (~quot_reg + SUM_W'(1)) : quot_reg;

        len_next  = len_reg;
        fill_next = fill_reg;
        wp_next   = wp_reg;
        sum_next  = sum_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;

        if (cfg.wr_en) begin
            len_next  = cfg_len[LEN_W-1:0];
            fill_next = '0;
            wp_next   = '0;
            sum_next  = '0;
        end else begin
            case (state_reg)
                ST_UPDATE: begin
                    // The oldest sample leaves the sum only once the window is full.
                    if (window_was_full) begin
                        sum_next = sum_reg + SUM_W'(sample_reg) - SUM_W'(ram_rd_data);
                    end else begin
                        sum_next  = sum_reg + SUM_W'(sample_reg);
                        fill_next = fill_reg + LEN_W'(1);
                    end
                    wp_next = (wp_inc >= len_reg) ? '0 : wp_inc[PTR_W-1:0];
                end
                ST_PREP: begin
                    quot_next = sum_reg[SUM_W-1] ? (~sum_reg + SUM_W'(1)) : sum_reg;
                    rem_next  = '0;
                    cnt_next  = CNT_W'(SUM_W);
                end
                ST_DIVIDE: begin
                    // Restoring division of the magnitude, one quotient bit a cycle.
                    if (!rem_diff[LEN_W]) begin
                        rem_next  = rem_diff[LEN_W-1:0];
                        quot_next = {quot_reg[SUM_W-2:0], 1'b1};
                    end else begin
                        rem_next  = rem_shift[LEN_W-1:0];
                        quot_next = {quot_reg[SUM_W-2:0], 1'b0};
                    end
                    cnt_next = cnt_reg - CNT_W'(1);
                end
                default: ;
            endcase
        end

        out_valid_next = out_valid_reg;
        if (load) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            len_reg       <= LEN_W'(INIT_LEN);
            fill_reg      <= '0;
            wp_reg        <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            fill_reg      <= fill_next;
            wp_reg        <= wp_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        if (pop) begin
            sample_reg <= q_sample;
        end
        if (state_reg == ST_PREP) begin
            neg_reg       <= sum_reg[SUM_W-1];
            full_flag_reg <= (fill_reg == len_reg);
        end
        if (load) begin
            avg_reg      <= quot_signed[SAMPLE_BITS-1:0];
            out_full_reg <= full_flag_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TDATA_W'(unsigned'(avg_reg));
    assign m_axis_tuser  = out_full_reg;

endmodule

FILE: hw/rtl/running_sum_moving_average_unit.sv
// Running-sum moving average unit: top level joining the input queue and the
// averaging engine. Depends on rsma_pkg, rsma_front, rsma_engine and rsma_ram.
//
// Each sample beat yields one result beat: the running sum of the last N
// samples (N = window_length) divided by the number of samples held so far,
// truncated toward zero, with tuser high once the window is full. Writing
// window_length (0 is taken as 1, values above WINDOW_MAX as WINDOW_MAX)
// restarts the window; write it only while no beat is in flight. Each sample
// passes through ring read, sum update, divider set-up, the bit-serial
// divider that forms one quotient bit per cycle, and result load. A two-beat
// input queue and a result register let either side stall independently.
// There is no clearing pass after reset; the ring is read for each sample,
// but a slot's value is used only after it has been written.
module running_sum_moving_average_unit #(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [rsma_pkg::CFG_BITS-1:0]         cfg_wr_data,   // window_length
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,   // sample
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] m_axis_tdata,   // average
    output logic                                  m_axis_tuser    // window_full
);
    import rsma_pkg::*;

    cfg_write_t                    cfg;
    engine_status_t                eng_status;
    logic                          q_valid;
    logic signed [SAMPLE_BITS-1:0] q_sample;

    assign cfg.wr_en   = cfg_wr_en;
    assign cfg.wr_data = cfg_wr_data;

    rsma_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .eng_status    (eng_status),
        .q_valid       (q_valid),
        .q_sample      (q_sample)
    );

    rsma_engine #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_engine (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .q_valid       (q_valid),
        .q_sample      (q_sample),
        .eng_status    (eng_status),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // The engine never takes a beat from an empty queue.
    a_pop_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        eng_status.pop |-> q_valid)
        else $error("engine popped an empty queue");

    // A waiting beat is taken as soon as the engine is idle.
    a_idle_takes_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (eng_status.idle && q_valid) |-> eng_status.pop)
        else $error("idle engine left a queued beat waiting");

    // A result is loaded only into a free or draining output register.
    a_load_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        eng_status.load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result overwrote an untaken beat");

    // A loaded result is presented on the next cycle.
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        eng_status.load |=> m_axis_tvalid)
        else $error("loaded result not presented");

endmodule

FILE: test/running_sum_moving_average_unit_test.sv
// Self-checking testbench for the running-sum moving average unit: predicts each average
// and full-window flag, compares every result beat, and covers windows of 1 to 64.
// Depends on rsma_pkg and the running_sum_moving_average_unit RTL; nothing else.
module running_sum_moving_average_unit_test;

    import rsma_pkg::*;

    localparam int WINDOW_MAX   = 64;
    localparam int SAMPLE_BITS  = 24;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE_CYCLES = 40;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 24'sh800000;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] average;
        logic                   window_full;
    } average_result_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_BITS-1:0]    cfg_wr_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [SAMPLE_BITS-1:0] s_axis_tdata = '0;   // sample
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [SAMPLE_BITS-1:0] m_axis_tdata;        // average
    logic                   m_axis_tuser;        // window_full

    // Predicted state of the window.
    logic signed [SAMPLE_BITS-1:0] window_ring [WINDOW_MAX];
    longint                        window_sum;
    int                            window_fill;
    int                            window_wp;
    int                            window_len;

    average_result_t pending_averages [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int fail_count = 0;
    int samples_sent = 0;
    int averages_checked = 0;
    int window_writes = 0;
    int cycle_count = 0;

    running_sum_moving_average_unit #(
        .WINDOW_MAX (WINDOW_MAX),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin : result_check
        average_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_averages.size() == 0) begin
                $error("result beat with no sample outstanding: average %0d",
                       $signed(m_axis_tdata));
                fail_count++;
            end else begin
                want = pending_averages.pop_front();
                averages_checked++;
                if (m_axis_tdata !== want.average) begin
                    $error("average mismatch: expected %0d, actual %0d",
                           $signed(want.average), $signed(m_axis_tdata));
                    fail_count++;
                end
                if (m_axis_tuser !== want.window_full) begin
                    $error("window_full mismatch: expected %0b, actual %0b",
                           want.window_full, m_axis_tuser);
                    fail_count++;
                end
            end
        end
    end

    task automatic restart_window();
        window_sum  = 0;
        window_fill = 0;
        window_wp   = 0;
    endtask

    // Once the window is full the oldest sample sits at the write pointer.
    task automatic predict_average(input logic signed [SAMPLE_BITS-1:0] smp);
        average_result_t res;
        longint          quotient;
        if (window_fill >= window_len)
            window_sum -= window_ring[window_wp];
        else
            window_fill++;
        window_ring[window_wp] = smp;
        window_sum += smp;
        window_wp = (window_wp + 1 >= window_len) ? 0 : window_wp + 1;
        quotient = window_sum / longint'(window_fill);
        res.average     = quotient[SAMPLE_BITS-1:0];
        res.window_full = (window_fill == window_len);
        pending_averages.push_back(res);
    endtask

    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] smp);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        do @(posedge aclk); while (!s_axis_tready);
        predict_average(smp);
        samples_sent++;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (pending_averages.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Out-of-range lengths are clamped to 1..WINDOW_MAX by the block.
    task automatic write_window_length(input logic [CFG_BITS-1:0] value);
        int used;
        wait_drained();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        used = value;
        if (used < 1)
            used = 1;
        if (used > WINDOW_MAX)
            used = WINDOW_MAX;
        window_len = used;
        restart_window();
        window_writes++;
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] random_sample(input int style);
        case (style)
            1: return ($urandom_range(0, 1) != 0) ? SAMPLE_MAX : SAMPLE_MIN;
            2: return SAMPLE_MAX;
            3: return SAMPLE_MIN;
            default: begin
                case ($urandom_range(0, 7))
                    0: return SAMPLE_MAX;
                    1: return SAMPLE_MIN;
                    2: return SAMPLE_BITS'(int'($urandom_range(0, 15)) - 8);
                    3: return SAMPLE_MAX - SAMPLE_BITS'($urandom_range(0, 3));
                    4: return SAMPLE_MIN + SAMPLE_BITS'($urandom_range(0, 3));
                    default: return SAMPLE_BITS'($urandom);
                endcase
            end
        endcase
    endfunction

    // Default length of eight, filling the window and wrapping past it.
    task automatic test_default_window();
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MIN);
        send_sample('0);
        send_sample(SAMPLE_BITS'(-1));
        send_sample(SAMPLE_BITS'(1));
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_BITS'(-1));
    endtask

    task automatic test_window_length_limits();
        write_window_length('0);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_BITS'(-1));
        write_window_length(7'd1);
        send_sample(SAMPLE_BITS'(-3));
        send_sample(SAMPLE_MAX);
        write_window_length('1);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        write_window_length(7'd65);
        send_sample(SAMPLE_BITS'(-7));
        send_sample(SAMPLE_MIN);
        write_window_length(7'd64);
        send_sample(SAMPLE_BITS'(5));
        send_sample(SAMPLE_MIN);
    endtask

    // Runs of samples, each under a fresh window length, long enough to wrap unless cut short by the count.
    task automatic test_random_windows(input int send_pct, input int recv_pct, input int count);
        int remaining;
        int burst;
        int style;
        int len;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        remaining = count;
        while (remaining > 0) begin
            case ($urandom_range(0, 9))
                0: len = 1;
                1: len = 2;
                2: len = 64;
                3: len = $urandom_range(65, 127);
                4: len = 0;
                default: len = $urandom_range(1, 64);
            endcase
            write_window_length(len[CFG_BITS-1:0]);
            len = (len < 1) ? 1 : (len > WINDOW_MAX) ? WINDOW_MAX : len;
            burst = len + $urandom_range(0, len) + $urandom_range(1, 24);
            if (burst > remaining)
                burst = remaining;
            style = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
            repeat (burst) send_sample(random_sample(style));
            remaining -= burst;
        end
    endtask

    initial begin
        window_len = RESET_LENGTH > WINDOW_MAX ? WINDOW_MAX : RESET_LENGTH;
        restart_window();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_default_window();
        test_window_length_limits();
        test_random_windows(8, 82, 650);
        test_random_windows(82, 8, 650);
        test_random_windows(0, 0, 650);

        wait_drained();
        $display("Sent %0d samples and checked %0d averages across %0d window length writes,",
                 samples_sent, averages_checked, window_writes);
        $display("covering lengths 1 to 64, clamped writes and full-scale sample runs.");
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/rsma_pkg.sv
hw/rtl/rsma_ram.sv
hw/rtl/rsma_front.sv
hw/rtl/rsma_engine.sv
hw/rtl/running_sum_moving_average_unit.sv
test/running_sum_moving_average_unit_test.sv
